// File: design/trl_pkg.sv
// Shared types and constants for the tightest-range lookup table.
package trl_pkg;

   localparam int ENTRIES = 32;
   localparam int ADDR_W  = 32;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_W = $clog2(ENTRIES + 1);
   localparam int ID_W    = 5;
   localparam int POS_W   = 16;

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_LOWER = 2'd1,
      REQ_RAISE = 2'd2,
      REQ_FIND  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_NOMATCH = 2'd2,
      STAT_NOINDEX = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // broadcast to every cell; only the addressed cell acts
   typedef struct packed {
      logic              add;
      logic              lower;
      logic              raise;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] addr;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
   } cell_cmd_type;

   // best-so-far record walking down the chain during a find
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [IDX_W-1:0]  best_id;
      logic [ADDR_W-1:0] best_width;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
   } scan_type;

endpackage

// File: design/trl_cell.sv
// One table entry: holds its bounds and position, and folds itself into a passing find.
module trl_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [trl_pkg::IDX_W-1:0]   cell_index,
   input  logic [trl_pkg::COUNT_W-1:0] entry_count,
   input  logic [trl_pkg::ADDR_W-1:0]  find_addr,
   input  trl_pkg::cell_cmd_type       cmd,
   input  trl_pkg::scan_type           scan_prev,
   output trl_pkg::scan_type           scan_next
);
   import trl_pkg::*;

   logic [ADDR_W-1:0] low_ff, low_in;
   logic [ADDR_W-1:0] high_ff, high_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic [POS_W-1:0]  col_ff, col_in;
   scan_type          scan_ff, scan_in;

   logic              hit;
   logic              live;
   logic              match;
   logic [ADDR_W-1:0] width;

   always_comb begin
      hit     = (cmd.idx == cell_index);
      low_in  = low_ff;
      high_in = high_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (cmd.add && hit) begin
         low_in  = '1;
         high_in = '0;
         row_in  = cmd.row;
         col_in  = cmd.col;
      end
      if (cmd.lower && hit && (cmd.addr < low_ff)) begin
         low_in = cmd.addr;
      end
      if (cmd.raise && hit && (cmd.addr > high_ff)) begin
         high_in = cmd.addr;
      end
   end

   always_comb begin
      live    = (32'(cell_index) < 32'(entry_count));
      match   = live && (find_addr >= low_ff) && (find_addr < high_ff);
      width   = high_ff - low_ff;
      scan_in = scan_prev;
      // strict compare keeps the earliest entry on a tie
      if (scan_prev.valid && match && (!scan_prev.found || (width < scan_prev.best_width))) begin
         scan_in.found      = 1'b1;
         scan_in.best_id    = cell_index;
         scan_in.best_width = width;
         scan_in.row        = row_ff;
         scan_in.col        = col_ff;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in;
      end
   end

   assign scan_next = scan_ff;

endmodule

// File: design/tightest_range_lookup_table_top.sv
// Top level: request decode, entry count, the cell chain and the response register.
// Each entry lives in its own cell of a chain of ENTRIES cells. Add and bound-update
// requests answer in the cycle after acceptance. A find is registered at the head of the
// chain and moves one cell per cycle, each cell folding in its own range; the result is
// then registered in the hold register and, once the output is free, in the response
// register. One request is in flight at a time, and a new request is taken only once the
// output register is empty or its response leaves in that same cycle.
module tightest_range_lookup_table_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_type,
   input  logic [4:0]                 req_entry_index,
   input  logic [trl_pkg::ADDR_W-1:0] req_address_value,
   input  logic [15:0]                req_row_number,
   input  logic [15:0]                req_column_number,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [4:0]                 rsp_entry_id,
   output logic [15:0]                rsp_found_row,
   output logic [15:0]                rsp_found_column
);
   import trl_pkg::*;

   state_type         state_ff, state_in;
   logic [COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   scan_type          head_ff, head_in;
   scan_type          hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        status_ff, status_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic [POS_W-1:0]  col_ff, col_in;

   cell_cmd_type      cmd;
   scan_type          scan_link [ENTRIES+1];
   logic [ENTRIES:0]  link_valid;
   logic              out_free;
   logic              accept;
   logic              load_out;
   logic              idx_known;

   assign scan_link[0] = head_ff;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      trl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_W'(i)),
         .entry_count (entry_count_ff),
         .find_addr   (addr_ff),
         .cmd         (cmd),
         .scan_prev   (scan_link[i]),
         .scan_next   (scan_link[i+1])
      );
   end

   for (genvar i = 0; i <= ENTRIES; i++) begin : g_link_valid
      assign link_valid[i] = scan_link[i].valid;
   end

   always_comb begin
      out_free       = !rsp_valid_ff || !rsp_stall;
      req_stall      = !((state_ff == ST_IDLE) && out_free);
      accept         = req_valid && !req_stall;
      idx_known      = (32'(req_entry_index) < 32'(entry_count_ff));
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      addr_in        = addr_ff;
      head_in        = '0;
      hold_in        = hold_ff;
      load_out       = 1'b0;
      status_in      = STAT_OK;
      id_in          = '0;
      row_in         = '0;
      col_in         = '0;
      cmd            = '0;
      cmd.idx        = IDX_W'(req_entry_index);
      cmd.addr       = req_address_value;
      cmd.row        = req_row_number;
      cmd.col        = req_column_number;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_code_type'(req_type))
                  REQ_ADD: begin
                     load_out = 1'b1;
                     if (32'(entry_count_ff) < 32'(ENTRIES)) begin
                        cmd.add        = 1'b1;
                        cmd.idx        = IDX_W'(entry_count_ff);
                        status_in      = STAT_OK;
                        id_in          = ID_W'(entry_count_ff);
                        entry_count_in = entry_count_ff + COUNT_W'(1);
                     end else begin
                        status_in = STAT_FULL;
                     end
                  end
                  REQ_LOWER, REQ_RAISE: begin
                     load_out = 1'b1;
                     id_in    = req_entry_index;
                     if (idx_known) begin
                        cmd.lower = (req_code_type'(req_type) == REQ_LOWER);
                        cmd.raise = (req_code_type'(req_type) == REQ_RAISE);
                        status_in = STAT_OK;
                     end else begin
                        status_in = STAT_NOINDEX;
                     end
                  end
                  REQ_FIND: begin
                     addr_in       = req_address_value;
                     head_in.valid = 1'b1;
                     state_in      = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_link[ENTRIES].valid) begin
               hold_in  = scan_link[ENTRIES];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
               if (hold_ff.found) begin
                  status_in = STAT_OK;
                  id_in     = ID_W'(hold_ff.best_id);
                  row_in    = hold_ff.row;
                  col_in    = hold_ff.col;
               end else begin
                  status_in = STAT_NOMATCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      hold_ff <= hold_in;
      if (load_out) begin
         status_ff <= status_in;
         id_ff     <= id_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
      end
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         head_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         head_ff        <= head_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_id     = id_ff;
   assign rsp_found_row    = row_ff;
   assign rsp_found_column = col_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(entry_count_ff) <= 32'(ENTRIES))
      else $error("entry count past table size");

   a_one_find: assert property (@(posedge clock) disable iff (reset)
      $onehot0(link_valid))
      else $error("more than one find in the cell chain");

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_link[ENTRIES].valid |-> (state_ff == ST_SCAN))
      else $error("find result left the chain outside scan state");

   a_find_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_FIND)) |=> (head_ff.valid && (state_ff == ST_SCAN)))
      else $error("accepted find did not enter the chain");
`endif

endmodule
